/* hw/rtl/ssel_pkg.sv */
// Shared types and constants for the scanline sprite selector.
// No dependencies; every other file of the block imports this package.
package ssel_pkg;

  // Sizing of the line list and of the scan
  localparam int unsigned SPRITES_PER_LINE   = 96;
  localparam int unsigned SPRITES_PER_SCREEN = 381;

  // Payload field widths
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned LINE_W   = 9;
  localparam int unsigned HGT_W    = 6;
  localparam int unsigned IDX_W    = 9;
  localparam int unsigned SLOT_W   = 7;
  localparam int unsigned COUNT_W  = 7;

  // Internal counter widths, wide enough to hold the cap itself
  localparam int unsigned SCNT_W = $clog2(SPRITES_PER_SCREEN + 1);
  localparam int unsigned SEL_W  = $clog2(SPRITES_PER_LINE + 1);

  // Attribute word layout
  localparam int unsigned YCODE_LSB  = 7;
  localparam int unsigned STICKY_BIT = 6;

  // Height code at or above which a chain covers every line
  localparam logic [HGT_W-1:0] FULL_HEIGHT = 6'h20;
  // Rows per height step, as a shift
  localparam int unsigned ROW_SHIFT = 4;

  // Depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    KIND_ENTRY   = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  // One classified item handed from front to back
  typedef struct packed {
    logic                pick;
    logic                last;
    logic [IDX_W-1:0]    sprite_index;
    logic [SLOT_W-1:0]   slot;
    logic [COUNT_W-1:0]  line_count;
  } job_t;

endpackage

/* hw/rtl/ssel_if.sv */
// Valid/ready channel interfaces for the scanline sprite selector.
// Depends on ssel_pkg for field widths.
interface ssel_in_if import ssel_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [WORD_W-1:0]   attribute_word;
  logic [LINE_W-1:0]   line_number;
  logic                start_of_scan;
  logic [LINE_W-1:0]   carried_top;
  logic [HGT_W-1:0]    carried_height;
  logic                end_of_scan;

  modport source (
    output valid, attribute_word, line_number, start_of_scan,
           carried_top, carried_height, end_of_scan,
    input  ready
  );
  modport sink (
    input  valid, attribute_word, line_number, start_of_scan,
           carried_top, carried_height, end_of_scan,
    output ready
  );
endinterface

interface ssel_out_if import ssel_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                kind;
  logic [IDX_W-1:0]    sprite_index;
  logic [SLOT_W-1:0]   slot;
  logic [COUNT_W-1:0]  line_count;
  logic                final_res;

  modport source (
    output valid, kind, sprite_index, slot, line_count, final_res,
    input  ready
  );
  modport sink (
    input  valid, kind, sprite_index, slot, line_count, final_res,
    output ready
  );
endinterface

/* hw/rtl/scanline_sprite_selector.sv */
// Top level of the scanline sprite selector.
// Depends on ssel_pkg, ssel_if, ssel_front, ssel_queue and ssel_back.
//
// Usage:
//   in_i carries one sprite vertical attribute word per transfer, in sprite
//   order, with the line number and the scan markers. Mark the first word of
//   a scan with start_of_scan (loads the carried chain, clears counters) and
//   the last with end_of_scan.
//   out_o carries results: a selected-sprite entry (kind 0) per picked
//   sprite, and after the last word a count summary (kind 1). final_res is
//   high on the last result a word produces.
// Timing:
//   A word is classified in the cycle it transfers; its job passes through the
//   job queue and the output register to out_o, and waits longer when jobs queue ahead.
//   One word per cycle is taken while the job queue has room; the back end
//   delivers one result per cycle while the receiver is ready, so a word that
//   yields both an entry and a summary holds the back end for both results.
// Reset and stalls:
//   Reset clears the chain, counters, queue and output valid flag. When the
//   receiver holds ready low the output register keeps its result, the
//   queue fills, and in_i.ready drops once it is full (four jobs).
module scanline_sprite_selector import ssel_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ssel_in_if.sink    in_i,
  ssel_out_if.source out_o
);

  logic accept;
  logic push;
  logic pop;
  logic q_empty;
  logic q_full;
  job_t push_job;
  job_t head_job;

  // Take a word whenever the queue can hold what it produces
  assign in_i.ready = !q_full;
  assign accept     = in_i.valid && in_i.ready;

  ssel_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .word_i           (in_i.attribute_word),
    .line_i           (in_i.line_number),
    .start_i          (in_i.start_of_scan),
    .carried_top_i    (in_i.carried_top),
    .carried_height_i (in_i.carried_height),
    .last_i           (in_i.end_of_scan),
    .push_o           (push),
    .job_o            (push_job)
  );

  // Decouple classification from result delivery
  ssel_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .head_o  (head_job),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  ssel_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head_job),
    .empty_i        (q_empty),
    .pop_o          (pop),
    .ready_i        (out_o.ready),
    .valid_o        (out_o.valid),
    .kind_o         (out_o.kind),
    .sprite_index_o (out_o.sprite_index),
    .slot_o         (out_o.slot),
    .line_count_o   (out_o.line_count),
    .final_res_o    (out_o.final_res)
  );

endmodule

/* hw/rtl/ssel_front.sv */
// Front end: keeps the chain and counter state and classifies each word.
// Depends on ssel_pkg; emits job_t records toward the queue.
module ssel_front import ssel_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [WORD_W-1:0]   word_i,
  input  logic [LINE_W-1:0]   line_i,
  input  logic                start_i,
  input  logic [LINE_W-1:0]   carried_top_i,
  input  logic [HGT_W-1:0]    carried_height_i,
  input  logic                last_i,
  output logic                push_o,
  output job_t                job_o
);

  logic [LINE_W-1:0] top_q, top_d, top_b;
  logic [HGT_W-1:0]  hgt_q, hgt_d, hgt_b;
  logic              vis_q, vis_d, vis_b;
  logic [SCNT_W-1:0] scnt_q, scnt_d, scnt_b;
  logic [SEL_W-1:0]  sel_q, sel_d, sel_b;
  logic              full_q, full_d, full_b;

  logic              active;
  logic              pick;
  logic [LINE_W-1:0] ycode;
  logic [LINE_W-1:0] new_top;
  logic [HGT_W-1:0]  new_hgt;
  logic [LINE_W-1:0] row_ofs;
  logic              new_vis;

  always_comb begin
    // start of scan clears counters and loads the carried chain first
    if (start_i) begin
      top_b  = carried_top_i;
      hgt_b  = carried_height_i;
      vis_b  = 1'b0;
      scnt_b = '0;
      sel_b  = '0;
      full_b = 1'b0;
    end else begin
      top_b  = top_q;
      hgt_b  = hgt_q;
      vis_b  = vis_q;
      scnt_b = scnt_q;
      sel_b  = sel_q;
      full_b = full_q;
    end

    active  = !full_b && (scnt_b < SCNT_W'(SPRITES_PER_SCREEN));
    ycode   = word_i[WORD_W-1:YCODE_LSB];
    new_top = LINE_W'(0) - ycode;
    new_hgt = word_i[HGT_W-1:0];
    row_ofs = line_i - new_top;
    new_vis = (new_hgt != '0) &&
              ((new_hgt >= FULL_HEIGHT) ||
               ({1'b0, row_ofs} < {new_hgt, ROW_SHIFT'(0)}));

    top_d = top_b;
    hgt_d = hgt_b;
    vis_d = vis_b;
    if (active && !word_i[STICKY_BIT]) begin
      top_d = new_top;
      hgt_d = new_hgt;
      vis_d = new_vis;
    end

    pick   = active && vis_d && (hgt_d != '0);
    sel_d  = sel_b + SEL_W'(pick);
    full_d = full_b || (pick && (sel_d >= SEL_W'(SPRITES_PER_LINE)));
    scnt_d = scnt_b + SCNT_W'(active);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q  <= '0;
      hgt_q  <= '0;
      vis_q  <= 1'b0;
      scnt_q <= '0;
      sel_q  <= '0;
      full_q <= 1'b0;
    end else if (accept_i) begin
      top_q  <= top_d;
      hgt_q  <= hgt_d;
      vis_q  <= vis_d;
      scnt_q <= scnt_d;
      sel_q  <= sel_d;
      full_q <= full_d;
    end
  end

  assign push_o             = accept_i && (pick || last_i);
  assign job_o.pick         = pick;
  assign job_o.last         = last_i;
  assign job_o.sprite_index = scnt_b[IDX_W-1:0];
  assign job_o.slot         = sel_b[SLOT_W-1:0];
  assign job_o.line_count   = sel_d[COUNT_W-1:0];

endmodule

/* hw/rtl/ssel_queue.sv */
// Short job queue between front and back ends.
// Depends on ssel_pkg for job_t and the queue depth.
module ssel_queue import ssel_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  job_t  job_i,
  input  logic  pop_i,
  output job_t  head_o,
  output logic  empty_o,
  output logic  full_o
);

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("pop from empty queue");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + QCNT_W'(1)))
    else $error("queue count did not advance on push");

  a_head_is_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (head_o.pick || head_o.last))
    else $error("queue holds a job with no result");

endmodule

/* hw/rtl/ssel_back.sv */
// Back end: expands queued jobs into result transfers through an output register.
// Depends on ssel_pkg; drives the result channel.
module ssel_back import ssel_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  job_t               head_i,
  input  logic               empty_i,
  output logic               pop_o,
  input  logic               ready_i,
  output logic               valid_o,
  output logic               kind_o,
  output logic [IDX_W-1:0]   sprite_index_o,
  output logic [SLOT_W-1:0]  slot_o,
  output logic [COUNT_W-1:0] line_count_o,
  output logic               final_res_o
);

  logic               valid_q;
  logic               second_q, second_d;
  kind_e              kind_q, kind_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic               fin_q, fin_d;
  logic               load;
  logic               summary;

  assign load    = !empty_i && (!valid_q || ready_i);
  // summary goes out when the entry of this job is already sent or there is none
  assign summary = second_q || !head_i.pick;
  assign pop_o   = load && (summary || !head_i.last);

  always_comb begin
    second_d = second_q;
    kind_d   = kind_q;
    idx_d    = idx_q;
    slot_d   = slot_q;
    count_d  = count_q;
    fin_d    = fin_q;
    if (load) begin
      second_d = !summary && head_i.last;
      count_d  = head_i.line_count;
      if (summary) begin
        kind_d = KIND_SUMMARY;
        idx_d  = '0;
        slot_d = '0;
        fin_d  = 1'b1;
      end else begin
        kind_d = KIND_ENTRY;
        idx_d  = head_i.sprite_index;
        slot_d = head_i.slot;
        fin_d  = !head_i.last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      second_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
      end else if (ready_i) begin
        valid_q <= 1'b0;
      end
      second_q <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    idx_q   <= idx_d;
    slot_q  <= slot_d;
    count_q <= count_d;
    fin_q   <= fin_d;
  end

  assign valid_o        = valid_q;
  assign kind_o         = kind_q;
  assign sprite_index_o = idx_q;
  assign slot_o         = slot_q;
  assign line_count_o   = count_q;
  assign final_res_o    = fin_q;

endmodule
